/* rtl/core/tgcp_pkg.sv */
// Shared types, character codes and result codes of the GPIO command parser.
package tgcp_pkg;

    localparam int NUM_PINS_DEFAULT = 8;
    localparam int OUT_PINS         = 8;

    // Character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_T    = 8'h74;

    typedef enum logic [1:0] {
        PH_OP     = 2'd0,
        PH_DIGITS = 2'd1,
        PH_REST   = 2'd2
    } parse_phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_OP    = 3'd2,
        ST_BAD_MODE  = 3'd3,
        ST_BAD_VALUE = 3'd4,
        ST_PIN_RANGE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OPK_NONE = 2'd0,
        OPK_MODE = 2'd1,
        OPK_SET  = 2'd2,
        OPK_READ = 2'd3
    } op_kind_t;

    // Line parsed so far
    typedef struct packed {
        parse_phase_t phase;
        logic [7:0]   op_char;
        logic [7:0]   pin_number;
        logic [7:0]   value_char;
    } line_t;

    // One result of a line
    typedef struct packed {
        status_t    status;
        op_kind_t   op_kind;
        logic [7:0] pin_index;
        logic       read_level;
        logic [7:0] dir_bits;
        logic [7:0] drive_bits;
        logic [7:0] pullup_bits;
    } result_t;

    function automatic logic is_line_end(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

/* rtl/core/tgcp_stream_if.sv */
// Valid/ready channels of the GPIO command parser: received bytes in, line results out.
interface tgcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [7:0] pin_levels;

    modport source (output valid, rx_byte, pin_levels, input ready);
    modport sink   (input valid, rx_byte, pin_levels, output ready);
endinterface

interface tgcp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] op_kind;
    logic [7:0] pin_index;
    logic       read_level;
    logic [7:0] dir_bits;
    logic [7:0] drive_bits;
    logic [7:0] pullup_bits;

    modport source (output valid, status, op_kind, pin_index, read_level,
                    dir_bits, drive_bits, pullup_bits, input ready);
    modport sink   (input valid, status, op_kind, pin_index, read_level,
                    dir_bits, drive_bits, pullup_bits, output ready);
endinterface

/* rtl/core/tgcp_line_parser.sv */
// Per-byte line parser: op character, decimal pin number, value character.
module tgcp_line_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output tgcp_pkg::line_t   line
);

    tgcp_pkg::parse_phase_t phase_reg, phase_next;
    logic [7:0] op_reg, op_next;
    logic [7:0] pin_reg, pin_next;
    logic [7:0] val_reg, val_next;
    logic       line_end;
    logic       is_digit;

    assign line_end = tgcp_pkg::is_line_end(rx_byte);
    assign is_digit = (rx_byte >= tgcp_pkg::CH_ZERO) && (rx_byte <= tgcp_pkg::CH_NINE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (line_end)
            begin
                phase_next = tgcp_pkg::PH_OP;
            end
            else
            begin
                case (phase_reg)
                    tgcp_pkg::PH_OP:
                    begin
                        phase_next = (rx_byte == tgcp_pkg::CH_NUL) ? tgcp_pkg::PH_REST
                                                                  : tgcp_pkg::PH_DIGITS;
                    end
                    tgcp_pkg::PH_DIGITS:
                    begin
                        phase_next = is_digit ? tgcp_pkg::PH_DIGITS : tgcp_pkg::PH_REST;
                    end
                    default:
                    begin
                        phase_next = tgcp_pkg::PH_REST;
                    end
                endcase
            end
        end
    end

    // field updates
    always_comb
    begin
        op_next  = op_reg;
        pin_next = pin_reg;
        val_next = val_reg;
        if (step)
        begin
            if (line_end)
            begin
                op_next  = 8'd0;
                pin_next = 8'd0;
                val_next = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    tgcp_pkg::PH_OP:
                    begin
                        op_next = rx_byte;
                    end
                    tgcp_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            // x*10 = x*8 + x*2, wraps at 8 bits
                            pin_next = {pin_reg[4:0], 3'b000} + {pin_reg[6:0], 1'b0}
                                       + (rx_byte - tgcp_pkg::CH_ZERO);
                        end
                        else
                        begin
                            val_next = rx_byte;
                        end
                    end
                    default:
                    begin
                        val_next = val_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tgcp_pkg::PH_OP;
            op_reg    <= 8'd0;
            pin_reg   <= 8'd0;
            val_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            pin_reg   <= pin_next;
            val_reg   <= val_next;
        end
    end

    assign line.phase      = phase_reg;
    assign line.op_char    = op_reg;
    assign line.pin_number = pin_reg;
    assign line.value_char = val_reg;

endmodule

/* rtl/core/tgcp_cmd_exec.sv */
// Command execution on a finished line and the per-pin direction, drive and pull-up bits.
module tgcp_cmd_exec #(
    parameter int NUM_PINS = tgcp_pkg::NUM_PINS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  tgcp_pkg::line_t   line,
    input  logic [7:0]        pin_levels,
    output tgcp_pkg::result_t result
);

    logic [NUM_PINS-1:0] dir_reg, dir_next, dir_cmd;
    logic [NUM_PINS-1:0] drv_reg, drv_next, drv_cmd;
    logic [NUM_PINS-1:0] pu_reg,  pu_next,  pu_cmd;
    logic [NUM_PINS-1:0] pin_mask;
    logic                in_range;
    logic                val_mode_ok;
    logic                val_set_ok;
    tgcp_pkg::status_t   status;
    tgcp_pkg::op_kind_t  kind;
    logic                rd;
    logic [7:0]          dir8, drv8, pu8;

    assign in_range = 32'(line.pin_number) < NUM_PINS;

    always_comb
    begin
        for (int i = 0; i < NUM_PINS; i++)
        begin
            pin_mask[i] = (line.pin_number == 8'(i));
        end
    end

    assign val_mode_ok = (line.value_char == tgcp_pkg::CH_I) ||
                         (line.value_char == tgcp_pkg::CH_P) ||
                         (line.value_char == tgcp_pkg::CH_O);
    assign val_set_ok  = (line.value_char == tgcp_pkg::CH_H) ||
                         (line.value_char == tgcp_pkg::CH_L) ||
                         (line.value_char == tgcp_pkg::CH_T);

    always_comb
    begin
        status  = tgcp_pkg::ST_OK;
        kind    = tgcp_pkg::OPK_NONE;
        rd      = 1'b0;
        dir_cmd = dir_reg;
        drv_cmd = drv_reg;
        pu_cmd  = pu_reg;
        case (line.op_char)
            tgcp_pkg::CH_NUL:
            begin
                status = tgcp_pkg::ST_TOO_SHORT;
            end
            tgcp_pkg::CH_M:
            begin
                kind = tgcp_pkg::OPK_MODE;
                if (line.value_char == tgcp_pkg::CH_NUL)
                    status = tgcp_pkg::ST_TOO_SHORT;
                else if (!val_mode_ok)
                    status = tgcp_pkg::ST_BAD_MODE;
                else if (!in_range)
                    status = tgcp_pkg::ST_PIN_RANGE;
                else if (line.value_char == tgcp_pkg::CH_I)
                begin
                    dir_cmd = dir_reg & ~pin_mask;
                    pu_cmd  = pu_reg & ~pin_mask;
                end
                else if (line.value_char == tgcp_pkg::CH_P)
                begin
                    dir_cmd = dir_reg & ~pin_mask;
                    pu_cmd  = pu_reg | pin_mask;
                end
                else
                begin
                    dir_cmd = dir_reg | pin_mask;
                    pu_cmd  = pu_reg & ~pin_mask;
                end
            end
            tgcp_pkg::CH_S:
            begin
                kind = tgcp_pkg::OPK_SET;
                if (line.value_char == tgcp_pkg::CH_NUL)
                    status = tgcp_pkg::ST_TOO_SHORT;
                else if (!val_set_ok)
                    status = tgcp_pkg::ST_BAD_VALUE;
                else if (!in_range)
                    status = tgcp_pkg::ST_PIN_RANGE;
                else if (line.value_char == tgcp_pkg::CH_H)
                    drv_cmd = drv_reg | pin_mask;
                else if (line.value_char == tgcp_pkg::CH_L)
                    drv_cmd = drv_reg & ~pin_mask;
                else
                    drv_cmd = drv_reg ^ pin_mask;
            end
            tgcp_pkg::CH_R:
            begin
                kind = tgcp_pkg::OPK_READ;
                if (!in_range)
                    status = tgcp_pkg::ST_PIN_RANGE;
                else if (line.pin_number[7:3] == 5'd0)
                    rd = pin_levels[line.pin_number[2:0]];
            end
            default:
            begin
                status = tgcp_pkg::ST_BAD_OP;
            end
        endcase
    end

    assign dir_next = commit ? dir_cmd : dir_reg;
    assign drv_next = commit ? drv_cmd : drv_reg;
    assign pu_next  = commit ? pu_cmd  : pu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= '0;
            drv_reg <= '0;
            pu_reg  <= '0;
        end
        else
        begin
            dir_reg <= dir_next;
            drv_reg <= drv_next;
            pu_reg  <= pu_next;
        end
    end

    // pins above bit 7 stay internal; missing pins read as zero
    for (genvar g = 0; g < tgcp_pkg::OUT_PINS; g++)
    begin : g_out
        if (g < NUM_PINS)
        begin : g_pin
            assign dir8[g] = dir_cmd[g];
            assign drv8[g] = drv_cmd[g];
            assign pu8[g]  = pu_cmd[g];
        end
        else
        begin : g_none
            assign dir8[g] = 1'b0;
            assign drv8[g] = 1'b0;
            assign pu8[g]  = 1'b0;
        end
    end

    assign result.status      = status;
    assign result.op_kind     = kind;
    assign result.pin_index   = line.pin_number;
    assign result.read_level  = rd;
    assign result.dir_bits    = dir8;
    assign result.drive_bits  = drv8;
    assign result.pullup_bits = pu8;

endmodule

/* rtl/core/tty_gpio_command_parser_unit.sv */
// Top level of the serial line GPIO command parser.
//
//  Channel | Dir | Payload                                        | Transfer
//  --------+-----+------------------------------------------------+---------------------
//  in_ch   | in  | rx_byte, pin_levels                            | valid & ready
//  out_ch  | out | status, op_kind, pin_index, read_level,        | valid & ready
//          |     | dir_bits, drive_bits, pullup_bits              |
//
//  One byte per cycle sustained unless a line-end byte waits on a held result;
//  a line-end byte's result is offered on out_ch once the byte has passed the
//  input register and the result register has loaded, which waits while out_ch
//  still holds an earlier result.
//  Reset (rst_n low, asynchronous) empties both registers, clears the line
//  being parsed and sets all pins to input, drive low, pull-up off.
//  While out_ch waits, other bytes keep flowing through the input register;
//  a line-end byte stalls there, and with it every byte behind it.
module tty_gpio_command_parser_unit #(
    parameter int NUM_PINS = tgcp_pkg::NUM_PINS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    tgcp_in_if.sink     in_ch,
    tgcp_out_if.source  out_ch
);

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic [7:0] s1_levels_reg;
    logic       s1_term;
    logic       s1_fire;
    logic       in_fire;

    // result register
    logic              out_valid_reg, out_valid_next;
    tgcp_pkg::result_t res_reg;
    tgcp_pkg::result_t res_comb;
    logic              out_free;
    logic              res_load;

    tgcp_pkg::line_t   line;

    assign s1_term  = tgcp_pkg::is_line_end(s1_byte_reg);
    assign out_free = !out_valid_reg || out_ch.ready;
    // a line-end byte needs the result slot; any other byte just updates the parser
    assign s1_fire  = s1_valid_reg && (!s1_term || out_free);
    assign res_load = s1_fire && s1_term;

    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = res_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg   <= in_ch.rx_byte;
            s1_levels_reg <= in_ch.pin_levels;
        end
        if (res_load)
        begin
            res_reg <= res_comb;
        end
    end

    tgcp_line_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_fire),
        .rx_byte (s1_byte_reg),
        .line    (line)
    );

    // executes on the line held by the parser when the line-end byte arrives
    tgcp_cmd_exec #(
        .NUM_PINS (NUM_PINS)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (res_load),
        .line       (line),
        .pin_levels (s1_levels_reg),
        .result     (res_comb)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = res_reg.status;
    assign out_ch.op_kind     = res_reg.op_kind;
    assign out_ch.pin_index   = res_reg.pin_index;
    assign out_ch.read_level  = res_reg.read_level;
    assign out_ch.dir_bits    = res_reg.dir_bits;
    assign out_ch.drive_bits  = res_reg.drive_bits;
    assign out_ch.pullup_bits = res_reg.pullup_bits;

    // a result only appears after a line-end byte has been consumed
    a_result_from_line_end : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_term))
        else $error("result appeared without a line-end byte");

    // a line end always returns the parser to the op phase
    a_line_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (line.phase == tgcp_pkg::PH_OP && line.op_char == 8'd0
                      && line.pin_number == 8'd0))
        else $error("parser not cleared after line end");

    // a reported level only comes from a successful read
    a_read_level_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.read_level) |->
            (res_reg.status == tgcp_pkg::ST_OK && res_reg.op_kind == tgcp_pkg::OPK_READ))
        else $error("read level set on a failed or non-read line");

    // range failures only for pins beyond the bank
    a_range_status : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status == tgcp_pkg::ST_PIN_RANGE) |->
            (32'(res_reg.pin_index) >= NUM_PINS))
        else $error("pin range status on an in-range pin");

endmodule

/* tb/gpio_cmd_checker.sv */
// Line result predictor and scoreboard for the serial GPIO command parser.
module gpio_cmd_checker #(
    parameter int NUM_PINS = tgcp_pkg::NUM_PINS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    tgcp_in_if         in_ch,
    tgcp_out_if        out_ch,
    output int         errors,
    output int         results_due,
    output int         lines_checked,
    output logic [5:0] statuses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tgcp_pkg::*;

    // Line being parsed
    parse_phase_t ln_phase;
    logic [7:0]   ln_op;
    logic [7:0]   ln_pin;
    logic [7:0]   ln_val;

    // Pin bank, wide enough for banks of up to 32 pins
    logic [31:0]  dir_q;
    logic [31:0]  drv_q;
    logic [31:0]  pu_q;

    result_t      line_results_due[$];

    // Runs the finished line against the pin bank and builds its result.
    function automatic result_t run_command(input logic [7:0] levels);
        result_t     r;
        logic        in_rng;
        logic [31:0] pin_mask;
        in_rng   = (32'(ln_pin) < NUM_PINS);
        pin_mask = in_rng ? (32'd1 << ln_pin) : 32'd0;
        r.status     = ST_OK;
        r.op_kind    = OPK_NONE;
        r.pin_index  = ln_pin;
        r.read_level = 1'b0;
        if (ln_op == CH_NUL) begin
            r.status = ST_TOO_SHORT;
        end
        else if (ln_op == CH_M) begin
            r.op_kind = OPK_MODE;
            if (ln_val == CH_NUL)
                r.status = ST_TOO_SHORT;
            else if (ln_val != CH_I && ln_val != CH_P && ln_val != CH_O)
                r.status = ST_BAD_MODE;
            else if (!in_rng)
                r.status = ST_PIN_RANGE;
            else if (ln_val == CH_I) begin
                dir_q = dir_q & ~pin_mask;
                pu_q  = pu_q & ~pin_mask;
            end
            else if (ln_val == CH_P) begin
                dir_q = dir_q & ~pin_mask;
                pu_q  = pu_q | pin_mask;
            end
            else begin
                dir_q = dir_q | pin_mask;
                pu_q  = pu_q & ~pin_mask;
            end
        end
        else if (ln_op == CH_S) begin
            r.op_kind = OPK_SET;
            if (ln_val == CH_NUL)
                r.status = ST_TOO_SHORT;
            else if (ln_val != CH_H && ln_val != CH_L && ln_val != CH_T)
                r.status = ST_BAD_VALUE;
            else if (!in_rng)
                r.status = ST_PIN_RANGE;
            else if (ln_val == CH_H)
                drv_q = drv_q | pin_mask;
            else if (ln_val == CH_L)
                drv_q = drv_q & ~pin_mask;
            else
                drv_q = drv_q ^ pin_mask;
        end
        else if (ln_op == CH_R) begin
            r.op_kind = OPK_READ;
            if (!in_rng)
                r.status = ST_PIN_RANGE;
            else if (ln_pin < 8'd8)
                r.read_level = levels[ln_pin[2:0]];
        end
        else begin
            r.status = ST_BAD_OP;
        end
        r.dir_bits    = dir_q[7:0];
        r.drive_bits  = drv_q[7:0];
        r.pullup_bits = pu_q[7:0];
        return r;
    endfunction

    function automatic void clear_line();
        ln_phase = PH_OP;
        ln_op    = CH_NUL;
        ln_pin   = 8'd0;
        ln_val   = CH_NUL;
    endfunction

    function automatic void take_rx_byte(input logic [7:0] b, input logic [7:0] levels);
        if (b == CH_LF || b == CH_CR) begin
            line_results_due.push_back(run_command(levels));
            clear_line();
        end
        else begin
            case (ln_phase)
                PH_OP:
                begin
                    ln_op    = b;
                    ln_phase = (b == CH_NUL) ? PH_REST : PH_DIGITS;
                end
                PH_DIGITS:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                        ln_pin = ln_pin * 8'd10 + (b - CH_ZERO);
                    else begin
                        ln_val   = b;
                        ln_phase = PH_REST;
                    end
                end
                default: ln_phase = PH_REST;
            endcase
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: line %0d %s mismatch, expected %0d actual %0d",
                     $time, lines_checked, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            clear_line();
            dir_q = 32'd0;
            drv_q = 32'd0;
            pu_q  = 32'd0;
            line_results_due.delete();
            errors        = 0;
            lines_checked = 0;
            statuses_seen = 6'd0;
        end
        else begin
            if (in_ch.valid && in_ch.ready)
                take_rx_byte(in_ch.rx_byte, in_ch.pin_levels);
            if (out_ch.valid && out_ch.ready) begin
                if (line_results_due.size() == 0) begin
                    $display("%0t ns: result transfer with no line pending, status %0d",
                             $time, out_ch.status);
                    errors++;
                end
                else begin
                    want = line_results_due.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("op_kind", want.op_kind, out_ch.op_kind);
                    check_field("pin_index", want.pin_index, out_ch.pin_index);
                    check_field("read_level", want.read_level, out_ch.read_level);
                    check_field("dir_bits", want.dir_bits, out_ch.dir_bits);
                    check_field("drive_bits", want.drive_bits, out_ch.drive_bits);
                    check_field("pullup_bits", want.pullup_bits, out_ch.pullup_bits);
                    if (want.status <= ST_PIN_RANGE)
                        statuses_seen[want.status] = 1'b1;
                    lines_checked++;
                end
            end
        end
        results_due = line_results_due.size();
    end

endmodule

/* tb/tty_gpio_command_parser_unit_tb.sv */
// Stimulus, handshake pacing and verdict for the serial GPIO command parser.
module tty_gpio_command_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgcp_pkg::*;

    localparam int NUM_PINS   = NUM_PINS_DEFAULT;
    // Long receiver hold-off: the input stalls behind a held result
    localparam int HOLD_TICKS = 90;

    logic clk;
    logic rst_n;

    tgcp_in_if  in_ch ();
    tgcp_out_if out_ch ();

    int         errors;
    int         results_due;
    int         lines_checked;
    logic [5:0] statuses_seen;

    // Pacing knobs, percent of cycles spent idle on each side
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_asked;
    int bytes_sent;

    tty_gpio_command_parser_unit #(.NUM_PINS(NUM_PINS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    gpio_cmd_checker #(.NUM_PINS(NUM_PINS)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .errors        (errors),
        .results_due   (results_due),
        .lines_checked (lines_checked),
        .statuses_seen (statuses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop; a correct run takes a small fraction of this
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off counted here
    // whenever the stimulus asks for one.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_TICKS;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // One byte transfer. Entered and left at a falling edge, so valid is
    // assigned at most once per time step.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid      <= 1'b0;
            in_ch.rx_byte    <= 8'($urandom_range(255));
            in_ch.pin_levels <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.rx_byte    <= b;
        in_ch.pin_levels <= 8'($urandom_range(255));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Drop valid and hold back until every line result has come out.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed commands with random pins and values; the rest is
    // noise, unknown ops, missing or odd values and trailing junk.
    task automatic send_random_line();
        int         pick;
        int         pin;
        logic [7:0] op;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(255)));
        end
        else begin
            case ($urandom_range(2))
                0:       op = CH_M;
                1:       op = CH_S;
                default: op = CH_R;
            endcase
            if (pick < 16)
                op = 8'($urandom_range(255));
            push_byte(op);
            // Mostly in range; the odd one past the bank or wrapping past 255
            if ($urandom_range(99) < 85)
                pin = $urandom_range(NUM_PINS - 1);
            else
                pin = $urandom_range(999);
            if ($urandom_range(9) == 0)
                push_byte(CH_ZERO);
            if ($urandom_range(19) != 0)
                send_str($sformatf("%0d", pin));
            pick = $urandom_range(99);
            if (pick < 80) begin
                case ($urandom_range(2))
                    0:       push_byte(op == CH_S ? CH_H : CH_I);
                    1:       push_byte(op == CH_S ? CH_L : CH_P);
                    default: push_byte(op == CH_S ? CH_T : CH_O);
                endcase
            end
            else if (pick < 86)
                push_byte(CH_NUL);
            else if (pick >= 93)
                push_byte(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        // Line end: LF, CR, or the CR LF pair (empty second line)
        case ($urandom_range(3))
            0, 1:    push_byte(CH_LF);
            2:       push_byte(CH_CR);
            default:
            begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        endcase
    endtask

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = 8'd0;
        in_ch.pin_levels  = 8'd0;
        sender_idle_pct   = 21;
        receiver_idle_pct = 46;
        hold_asked        = 0;
        bytes_sent        = 0;
        rst_n             = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines: status codes, every op and value, pin extremes
        push_byte(CH_CR);                       // empty line, then CR LF pair
        push_byte(CH_LF);
        push_byte(CH_NUL);                      // NUL op counts as missing
        push_byte(CH_LF);
        send_str("x5h");                        // unknown op
        push_byte(CH_CR);
        send_str("m7");                         // mode with no value
        push_byte(CH_LF);
        send_str("s3");                         // NUL as value
        push_byte(CH_NUL);
        push_byte(CH_LF);
        send_str("m3q");                        // bad mode
        push_byte(CH_LF);
        send_str("s255z");                      // bad value beats pin range
        push_byte(CH_LF);
        send_str("m8o");                        // first pin past the bank
        push_byte(CH_LF);
        send_str("m0o");
        push_byte(CH_LF);
        send_str("m258p");                      // wraps to pin 2
        push_byte(CH_LF);
        send_str("m7i");
        push_byte(CH_LF);
        send_str("s0h");
        push_byte(CH_LF);
        send_str("s0t");
        push_byte(CH_LF);
        send_str("s0l");
        push_byte(CH_LF);
        send_str("s7hjunk");                    // tail after the value ignored
        push_byte(CH_LF);
        send_str("r7");                         // read needs no value
        push_byte(CH_LF);
        send_str("r0");
        push_byte(CH_CR);
        send_str("r9x");                        // read out of range
        push_byte(CH_LF);
        send_str("mo");                         // no digits, pin 0
        push_byte(CH_LF);
        drain_results();

        // Random traffic under three pacing regimes
        while (bytes_sent < 600)
            send_random_line();
        drain_results();

        sender_idle_pct   = 46;
        receiver_idle_pct = 21;
        while (bytes_sent < 1150)
            send_random_line();
        drain_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        // Receiver holds off while lines keep coming, filling the block
        hold_asked++;
        repeat (20)
            send_random_line();
        drain_results();
        while (bytes_sent < 1700)
            send_random_line();
        drain_results();

        // Let any late or spurious transfer show up before the verdict
        repeat (10) @(negedge clk);

        $display("tb: %0d bytes sent, %0d line results checked", bytes_sent, lines_checked);
        $display("tb: status codes seen (5..0) %b, under three pacing regimes and a hold-off",
                 statuses_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
